FILE: rtl/keyed_probe_sampling_table_core_assert.svh
// assertion macros for the keyed probe sampling table core
// expects clk and rst in the scope of the module that uses them
`ifndef KEYED_PROBE_SAMPLING_TABLE_CORE_ASSERT_SVH
`define KEYED_PROBE_SAMPLING_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KPST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpst same-cycle check failed");

// next-cycle implication, checked out of reset
`define KPST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpst next-cycle check failed");

`endif

FILE: rtl/kpst_pkg.sv
// shared types and codes for the keyed probe sampling table core
// no dependencies
`default_nettype none

package kpst_pkg;

  localparam int unsigned TableRowsDefault = 16;
  localparam int unsigned KeyBitsDefault   = 64;
  localparam int unsigned KeyPortBits      = 64;
  localparam int unsigned WordBits         = 32;

  localparam logic [1:0] ActAdmit  = 2'd0;
  localparam logic [1:0] ActActive = 2'd1;
  localparam logic [1:0] ActDecide = 2'd2;
  localparam logic [1:0] ActProbe  = 2'd3;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StKeyMissing = 3'd1;
  localparam logic [2:0] StNoToken    = 3'd2;
  localparam logic [2:0] StZeroPeriod = 3'd3;
  localparam logic [2:0] StFull       = 3'd4;

  // request travelling along the row of cells
  typedef struct packed {
    logic                   valid;
    logic [1:0]             action;
    logic [KeyPortBits-1:0] key;
    logic                   key_present;
    logic [WordBits-1:0]    period;
    logic                   correct;
    logic [WordBits-1:0]    needed;
    logic                   found;
    logic                   answer;
    logic [2:0]             status;
  } token_t;

endpackage

`default_nettype wire

FILE: rtl/kpst_cell.sv
// one table row: key, active flag, period, decision counter and streak
// depends on kpst_pkg
`default_nettype none

module kpst_cell #(
  parameter int unsigned KEY_BITS = kpst_pkg::KeyBitsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire kpst_pkg::token_t tok_in,
  output kpst_pkg::token_t     tok_out
);

  logic                          used;
  logic                          active;
  logic [KEY_BITS-1:0]           row_key;
  logic [kpst_pkg::WordBits-1:0] period;
  logic [kpst_pkg::WordBits-1:0] dcount;
  logic [kpst_pkg::WordBits-1:0] streak;

  logic                          used_next;
  logic                          active_next;
  logic [KEY_BITS-1:0]           row_key_next;
  logic [kpst_pkg::WordBits-1:0] period_next;
  logic [kpst_pkg::WordBits-1:0] dcount_next;
  logic [kpst_pkg::WordBits-1:0] streak_next;
  kpst_pkg::token_t              tok_next;

  logic                          live;
  logic                          hit;
  logic                          append;
  logic [kpst_pkg::WordBits-1:0] dcount_inc;
  logic [kpst_pkg::WordBits-1:0] streak_inc;

  assign live = tok_in.valid && !tok_in.found && tok_in.key_present &&
                (tok_in.status == kpst_pkg::StOk);
  assign hit = live && used && (row_key == tok_in.key[KEY_BITS-1:0]);
  // first free row sees the request only after every used row has missed
  assign append = live && !used && (tok_in.action == kpst_pkg::ActAdmit);

  assign dcount_inc = (&dcount) ? dcount : dcount + 1'b1;
  assign streak_inc = (&streak) ? streak : streak + 1'b1;

  always_comb begin
    used_next    = used;
    active_next  = active;
    row_key_next = row_key;
    period_next  = period;
    dcount_next  = dcount;
    streak_next  = streak;
    tok_next     = tok_in;
    if (append) begin
      used_next      = 1'b1;
      row_key_next   = tok_in.key[KEY_BITS-1:0];
      period_next    = tok_in.period;
      dcount_next    = '0;
      active_next    = 1'b1;
      tok_next.found = 1'b1;
    end else if (hit) begin
      tok_next.found = 1'b1;
      case (tok_in.action)
        kpst_pkg::ActAdmit: begin
          period_next = tok_in.period;
          dcount_next = '0;
          active_next = 1'b1;
        end
        kpst_pkg::ActActive: begin
          tok_next.answer = active;
        end
        kpst_pkg::ActDecide: begin
          if (!active) begin
            tok_next.answer = 1'b1;
          end else if (dcount_inc >= period) begin
            dcount_next     = '0;
            tok_next.answer = 1'b1;
          end else begin
            dcount_next     = dcount_inc;
            tok_next.answer = 1'b0;
          end
        end
        default: begin
          if (active) begin
            if (!tok_in.correct) begin
              streak_next = '0;
            end else if (streak_inc >= tok_in.needed) begin
              active_next     = 1'b0;
              streak_next     = '0;
              tok_next.answer = 1'b1;
            end else begin
              streak_next = streak_inc;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    row_key <= row_key_next;
    period  <= period_next;
    dcount  <= dcount_next;
    if (rst) begin
      used    <= 1'b0;
      active  <= 1'b0;
      streak  <= '0;
      tok_out <= '0;
    end else begin
      used    <= used_next;
      active  <= active_next;
      streak  <= streak_next;
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/keyed_probe_sampling_table_core.sv
// keyed probe sampling table core: top level with entry checks and result register
// depends on kpst_pkg, kpst_cell and keyed_probe_sampling_table_core_assert.svh
//
// usage
//   one request channel (in_valid / in_ready) carries action, key and its
//   arguments; one result channel (out_valid / out_ready) carries status and
//   answer. every request gives exactly one result
//   the table is a row of TABLE_ROWS cells, one row per cell. a request is
//   registered at entry, then walks the row one cell per cycle; the cell that
//   holds its key updates itself, or on an admit the first free cell takes a new key
//   from acceptance to out_valid a request passes the entry register, the
//   register of each cell in turn and then the result register
//   one request in flight: a new request is not taken until the last has
//   left the row; it is taken while no request is in flight and the result
//   register is empty or being read
//   if the receiver stalls, the result is held and in_ready stays low
//   reset (rst, synchronous) empties the table: no rows, nothing active,
//   all streaks zero, no request in flight
`default_nettype none

module keyed_probe_sampling_table_core #(
  parameter int unsigned TABLE_ROWS = kpst_pkg::TableRowsDefault,
  parameter int unsigned KEY_BITS   = kpst_pkg::KeyBitsDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          action,
  input  wire logic [kpst_pkg::KeyPortBits-1:0]    key,
  input  wire logic                                key_present,
  input  wire logic                                token_present,
  input  wire logic [kpst_pkg::WordBits-1:0]       probe_period,
  input  wire logic                                probe_correct,
  input  wire logic [kpst_pkg::WordBits-1:0]       streak_needed,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               status,
  output logic                                     answer
);

  // chain[0] is the entry register, chain[i+1] the output of cell i
  kpst_pkg::token_t      chain [TABLE_ROWS+1];
  logic [TABLE_ROWS:0]   chain_valid;
  kpst_pkg::token_t      entry_next;
  kpst_pkg::token_t      tail;
  logic                  busy;
  logic                  in_accept;
  logic                  out_accept;
  logic [2:0]            entry_status;

  assign in_ready   = !busy && (!out_valid || out_ready);
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;
  assign tail       = chain[TABLE_ROWS];

  // checks before the walk: admit key, then token, then period; probe key only
  always_comb begin
    entry_status = kpst_pkg::StOk;
    if (action == kpst_pkg::ActAdmit) begin
      if (!key_present) begin
        entry_status = kpst_pkg::StKeyMissing;
      end else if (!token_present) begin
        entry_status = kpst_pkg::StNoToken;
      end else if (probe_period == '0) begin
        entry_status = kpst_pkg::StZeroPeriod;
      end
    end else if (action == kpst_pkg::ActProbe && !key_present) begin
      entry_status = kpst_pkg::StKeyMissing;
    end
  end

  always_comb begin
    entry_next.valid       = in_accept;
    entry_next.action      = action;
    entry_next.key         = key;
    entry_next.key_present = key_present;
    entry_next.period      = probe_period;
    entry_next.correct     = probe_correct;
    // a needed streak of zero behaves as one
    entry_next.needed      = (streak_needed == '0) ?
                             kpst_pkg::WordBits'(1) : streak_needed;
    entry_next.found       = 1'b0;
    // unknown keys may decide; the owning cell overrides this
    entry_next.answer      = (action == kpst_pkg::ActDecide);
    entry_next.status      = entry_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0] <= entry_next;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ROWS; gi++) begin : g_row
      kpst_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain[gi]),
        .tok_out (chain[gi+1])
      );
    end
    for (gi = 0; gi <= TABLE_ROWS; gi++) begin : g_valid
      assign chain_valid[gi] = chain[gi].valid;
    end
  endgenerate

  // result register; an admit that found no row and no free cell means full
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      answer <= tail.answer;
      if (tail.action == kpst_pkg::ActAdmit && tail.status == kpst_pkg::StOk &&
          !tail.found) begin
        status <= kpst_pkg::StFull;
      end else begin
        status <= tail.status;
      end
    end
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (tail.valid) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
    end
  end

  `include "keyed_probe_sampling_table_core_assert.svh"

  // never more than one request walking the row
  `KPST_ASSERT_NOW(a_single_request, 1'b1, $countones(chain_valid) <= 1)
  // a request leaving the row never overwrites an unread result
  `KPST_ASSERT_NOW(a_no_overwrite, tail.valid, !out_valid)
  // the walk belongs to the request held by busy
  `KPST_ASSERT_NOW(a_walk_busy, chain_valid != '0, busy)
  // every request leaving the row shows up as a result
  `KPST_ASSERT_NEXT(a_tail_result, tail.valid, out_valid)

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// testbench for keyed_probe_sampling_table_core: random and directed requests with a
// bit-true tracker of the distrust table; depends on kpst_pkg and the core rtl

typedef struct packed {
  logic [1:0]          action;
  logic [63:0]         key;
  logic                key_present;
  logic                token_present;
  logic [31:0]         period;
  logic                correct;
  logic [31:0]         needed;
} table_request_t;

typedef struct packed {
  logic [2:0] status;
  logic       answer;
} table_reply_t;

// tracks the table contents and the replies still owed by the core
class distrust_table_tracker;
  logic [63:0]    keys [kpst_pkg::TableRowsDefault];
  logic           active [kpst_pkg::TableRowsDefault];
  logic [31:0]    period [kpst_pkg::TableRowsDefault];
  logic [31:0]    decisions [kpst_pkg::TableRowsDefault];
  logic [31:0]    streak [kpst_pkg::TableRowsDefault];
  int unsigned    rows;
  table_reply_t   owed_replies [$];
  int             errors;

  function new();
    rows = 0;
    errors = 0;
    foreach (active[i]) begin
      active[i] = 1'b0;
      streak[i] = '0;
    end
  endfunction

  // work out the reply of one accepted request and update the table copy
  function void note_request(table_request_t r);
    table_reply_t rep;
    int           row;
    logic [31:0]  c;
    logic [31:0]  need;
    rep = '0;
    row = -1;
    if (r.key_present) begin
      for (int i = 0; i < rows; i++) begin
        if (keys[i] == r.key) begin
          row = i;
          break;
        end
      end
    end
    case (r.action)
      kpst_pkg::ActAdmit: begin
        if (!r.key_present) rep.status = kpst_pkg::StKeyMissing;
        else if (!r.token_present) rep.status = kpst_pkg::StNoToken;
        else if (r.period == '0) rep.status = kpst_pkg::StZeroPeriod;
        else begin
          if (row < 0) begin
            if (rows >= kpst_pkg::TableRowsDefault) begin
              rep.status = kpst_pkg::StFull;
            end else begin
              row = rows;
              keys[row] = r.key;
              rows++;
            end
          end
          if (row >= 0) begin
            period[row] = r.period;
            decisions[row] = '0;
            active[row] = 1'b1;
          end
        end
      end
      kpst_pkg::ActActive: rep.answer = (row >= 0) && active[row];
      kpst_pkg::ActDecide: begin
        if (row < 0 || !active[row]) begin
          rep.answer = 1'b1;
        end else begin
          c = decisions[row];
          if (c != '1) c++;
          if (c >= period[row]) begin
            decisions[row] = '0;
            rep.answer = 1'b1;
          end else begin
            decisions[row] = c;
          end
        end
      end
      default: begin
        if (!r.key_present) begin
          rep.status = kpst_pkg::StKeyMissing;
        end else if (row >= 0 && active[row]) begin
          need = (r.needed == '0) ? 32'd1 : r.needed;
          if (r.correct) begin
            if (streak[row] != '1) streak[row]++;
            if (streak[row] >= need) begin
              active[row] = 1'b0;
              streak[row] = '0;
              rep.answer = 1'b1;
            end
          end else begin
            streak[row] = '0;
          end
        end
      end
    endcase
    owed_replies.push_back(rep);
  endfunction

  function void check_reply(logic [2:0] status, logic answer);
    table_reply_t exp_rep;
    if (owed_replies.size() == 0) begin
      errors++;
      $display("%0t: reply with nothing owed, status %0d answer %0d",
               $time, status, answer);
      return;
    end
    exp_rep = owed_replies.pop_front();
    if (status !== exp_rep.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d",
               $time, exp_rep.status, status);
    end
    if (answer !== exp_rep.answer) begin
      errors++;
      $display("%0t: answer expected %0d actual %0d",
               $time, exp_rep.answer, answer);
    end
  endfunction

  function int owed();
    return owed_replies.size();
  endfunction
endclass

module tb;

  localparam int RandomRequests = 850;
  localparam int PoolSize       = 20;
  localparam int CycleLimit     = 500000;
  // walk along the row plus entry and result registers
  localparam int DrainCycles    = 2 * (kpst_pkg::TableRowsDefault + 2) + 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = kpst_pkg::ActAdmit;
  logic [63:0] key = '0;
  logic        key_present = 1'b0;
  logic        token_present = 1'b0;
  logic [31:0] probe_period = '0;
  logic        probe_correct = 1'b0;
  logic [31:0] streak_needed = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        answer;

  distrust_table_tracker tracker = new();

  logic [63:0] key_pool [PoolSize];
  int          requests_taken = 0;
  int          burst_left = 0;
  int          cycles = 0;

  always #5 clk = ~clk;

  keyed_probe_sampling_table_core #(
    .TABLE_ROWS (kpst_pkg::TableRowsDefault),
    .KEY_BITS   (kpst_pkg::KeyBitsDefault)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .key           (key),
    .key_present   (key_present),
    .token_present (token_present),
    .probe_period  (probe_period),
    .probe_correct (probe_correct),
    .streak_needed (streak_needed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .answer        (answer)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // every reply taken by the receiver is checked against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_reply(status, answer);
  end

  // receiver: phases of eager, patchy and sluggish taking; twice a long hold-off
  // so that the result register stays full and the core stops taking requests
  initial begin : reply_taker
    int mode;
    int phase_left;
    int hold_left;
    int next_hold_mark;
    mode = 0;
    phase_left = 0;
    hold_left = 0;
    next_hold_mark = 150;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && requests_taken >= next_hold_mark) begin
        hold_left = 400;
        next_hold_mark += 450;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 2);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic table_request_t mk(logic [1:0] act, logic [63:0] k, logic kp,
                                        logic tp, logic [31:0] per, logic cor,
                                        logic [31:0] need);
    table_request_t r;
    r.action = act;
    r.key = k;
    r.key_present = kp;
    r.token_present = tp;
    r.period = per;
    r.correct = cor;
    r.needed = need;
    return r;
  endfunction

  // every field random; keys half from the pool, half anywhere
  function automatic table_request_t random_request();
    table_request_t r;
    r.action = 2'($urandom_range(0, 3));
    r.key = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                        : {$urandom, $urandom};
    r.key_present = ($urandom_range(0, 3) != 0);
    r.token_present = ($urandom_range(0, 3) != 0);
    r.period = $urandom;
    r.correct = 1'($urandom_range(0, 1));
    r.needed = $urandom;
    return r;
  endfunction

  // offer one request, wait for the handshake, then either carry on with the
  // burst (valid stays high) or drop valid for a random gap
  task automatic offer_request(table_request_t r);
    in_valid      <= 1'b1;
    action        <= r.action;
    key           <= r.key;
    key_present   <= r.key_present;
    token_present <= r.token_present;
    probe_period  <= r.period;
    probe_correct <= r.correct;
    streak_needed <= r.needed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(r);
    requests_taken++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  initial begin : stimulus
    table_request_t directed [$];
    table_request_t r;
    logic [63:0]    pick;
    logic [31:0]    need;
    int             sent;
    int             steps;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // admit checks in order: key, token, period
    directed.push_back(mk(kpst_pkg::ActAdmit, key_pool[1], 1'b0, 1'b1, 32'd1, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActAdmit, key_pool[1], 1'b1, 1'b0, 32'd1, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActAdmit, key_pool[1], 1'b1, 1'b1, 32'd0, 1'b0, '0));
    // all-ones key with the shortest period: every decision allowed
    directed.push_back(mk(kpst_pkg::ActAdmit, key_pool[1], 1'b1, 1'b1, 32'd1, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActActive, key_pool[1], 1'b1, 1'b0, '0, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[1], 1'b1, 1'b0, '0, 1'b0, '0));
    // zero key with the longest period: decisions refused
    directed.push_back(mk(kpst_pkg::ActAdmit, key_pool[0], 1'b1, 1'b1, '1, 1'b1, '1));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[0], 1'b1, 1'b0, '0, 1'b0, '0));
    // missing key on the queries, and an unknown key
    directed.push_back(mk(kpst_pkg::ActActive, key_pool[0], 1'b0, 1'b0, '0, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[0], 1'b0, 1'b0, '0, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[5], 1'b1, 1'b0, '0, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[0], 1'b0, 1'b0, '0, 1'b1, 32'd1));
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[5], 1'b1, 1'b0, '0, 1'b1, 32'd1));
    // streak: wrong clears, huge need holds, need of two deactivates
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[0], 1'b1, 1'b0, '0, 1'b0, 32'd2));
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[0], 1'b1, 1'b0, '0, 1'b1, '1));
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[0], 1'b1, 1'b0, '0, 1'b1, 32'd2));
    directed.push_back(mk(kpst_pkg::ActActive, key_pool[0], 1'b1, 1'b0, '0, 1'b0, '0));
    // inactive row: probe ignored, decisions allowed
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[0], 1'b1, 1'b0, '0, 1'b1, 32'd1));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[0], 1'b1, 1'b0, '0, 1'b0, '0));
    // a need of zero acts as one
    directed.push_back(mk(kpst_pkg::ActProbe, key_pool[1], 1'b1, 1'b0, '0, 1'b1, '0));
    // re-admit keeps the row, period of two refuses then allows
    directed.push_back(mk(kpst_pkg::ActAdmit, key_pool[1], 1'b1, 1'b1, 32'd2, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[1], 1'b1, 1'b0, '0, 1'b0, '0));
    directed.push_back(mk(kpst_pkg::ActDecide, key_pool[1], 1'b1, 1'b0, '0, 1'b0, '0));
    foreach (directed[i]) offer_request(directed[i]);

    // mostly admit-then-use sequences on pool keys; the pool is larger than
    // the table, so the full-table case turns up once the rows run out
    sent = 0;
    while (sent < RandomRequests) begin
      r = random_request();
      if ($urandom_range(0, 9) < 8) begin
        pick = key_pool[$urandom_range(0, PoolSize - 1)];
        need = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 3));
        r.action = kpst_pkg::ActAdmit;
        r.key = pick;
        r.key_present = 1'b1;
        r.token_present = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) != 0) r.period = $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0) r.period = '0;
        offer_request(r);
        sent++;
        steps = $urandom_range(2, 10);
        repeat (steps) begin
          r = random_request();
          r.action = 2'($urandom_range(1, 3));
          r.key = pick;
          r.key_present = ($urandom_range(0, 19) != 0);
          r.correct = ($urandom_range(0, 4) != 0);
          r.needed = need;
          offer_request(r);
          sent++;
        end
      end else begin
        offer_request(r);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (tracker.owed() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/kpst_pkg.sv
rtl/kpst_cell.sv
rtl/keyed_probe_sampling_table_core.sv
tb/tb.sv
